// File: rtl/subset_enumerator_macros.svh
// Assertion macros used by the subset enumerator core.
`ifndef SUBSET_ENUMERATOR_MACROS_SVH
`define SUBSET_ENUMERATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("subset enumerator check failed");

// Next-cycle implication, checked outside reset.
`define SE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("subset enumerator check failed");

`endif

// File: rtl/subenum_pkg.sv
package subenum_pkg;

    localparam int POOL_MAX_DEF  = 16;
    localparam int POP_WIDTH_DEF = 16;

    localparam int SIZE_W     = 5;
    localparam int POS_W      = 4;
    localparam int PORT_POP_W = 16;
    localparam int MODEL_W    = 16;
    localparam int OP_W       = 2;
    localparam int SLOT_W     = 4;
    localparam int CFG_IDX_W  = 2;

    localparam logic [SIZE_W-1:0] POOL_SIZE_RST = 5'd1;
    localparam logic [SIZE_W-1:0] MIN_SIZE_RST  = 5'd1;
    localparam logic [SIZE_W-1:0] MAX_SIZE_RST  = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_NEXT    = 2'd1,
        OP_RESTART = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_SIZE = 2'd0,
        CFG_MIN_SIZE  = 2'd1,
        CFG_MAX_SIZE  = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BEGIN,
        ST_INIT,
        ST_ADV,
        ST_SCAN,
        ST_FILL,
        ST_EMIT_RD,
        ST_EMIT_PR,
        ST_EMIT_WR,
        ST_DONE
    } seq_state_t;

    // Effective size band derived from the configuration registers.
    typedef struct packed {
        logic [SIZE_W-1:0] n;
        logic [SIZE_W-1:0] lo;
        logic [SIZE_W-1:0] hi;
    } band_t;

    typedef struct packed {
        logic [POS_W-1:0]      member_position;
        logic [PORT_POP_W-1:0] member_population;
        logic [SIZE_W-1:0]     subset_size;
        logic [MODEL_W-1:0]    model_number;
        logic                  last_member;
        logic                  done_res;
    } result_t;

endpackage

// File: rtl/subenum_core.sv
`include "subset_enumerator_macros.svh"

module subenum_core #(
    parameter int POOL_MAX  = subenum_pkg::POOL_MAX_DEF,
    parameter int POP_WIDTH = subenum_pkg::POP_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [subenum_pkg::OP_W-1:0]       s_op,
    input  logic [subenum_pkg::SLOT_W-1:0]     s_slot,
    input  logic [subenum_pkg::PORT_POP_W-1:0] s_population,
    input  subenum_pkg::band_t                band,
    input  logic                              out_free,
    output subenum_pkg::result_t              res,
    output logic                              res_load
);
    import subenum_pkg::*;

    localparam int IDX_W = (POOL_MAX > 1) ? $clog2(POOL_MAX) : 1;
    localparam int XW    = (POP_WIDTH > PORT_POP_W) ? POP_WIDTH : PORT_POP_W;
    localparam int W6    = SIZE_W + 1;

    seq_state_t state_reg, state_next;
    logic [SIZE_W-1:0]  k_reg, k_next;
    logic [MODEL_W-1:0] model_reg, model_next;
    logic               started_reg, started_next;
    logic               exhausted_reg, exhausted_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   val_reg, val_next;
    logic [IDX_W-1:0]   hold_reg, hold_next;
    logic [W6-1:0]      from_reg, from_next;

    // Position memory and pool memory, one synchronous read port each.
    logic [IDX_W-1:0]     pos_mem [POOL_MAX];
    logic [IDX_W-1:0]     pos_rdata_reg;
    logic                 pos_we, pos_re;
    logic [IDX_W-1:0]     pos_waddr, pos_raddr, pos_wdata;
    logic [POP_WIDTH-1:0] pool_mem [POOL_MAX];
    logic [POP_WIDTH-1:0] pool_rdata_reg;
    logic                 pool_we, pool_re;
    logic [IDX_W-1:0]     pool_waddr, pool_raddr;
    logic [POP_WIDTH-1:0] pool_wdata;

    logic [XW-1:0]     pop_in_wide, pop_out_wide;
    logic              accept;
    logic [SIZE_W-1:0] km1;
    logic [W6-1:0]     k_try, lim_lhs, lim_rhs;
    logic              in_band, at_limit, idx_is_last;

    always_ff @(posedge clk) begin
        if (pos_we) begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        if (pos_re) begin
            pos_rdata_reg <= pos_mem[pos_raddr];
        end
    end

    always_ff @(posedge clk) begin
        if (pool_we) begin
            pool_mem[pool_waddr] <= pool_wdata;
        end
        if (pool_re) begin
            pool_rdata_reg <= pool_mem[pool_raddr];
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            model_reg     <= '0;
            started_reg   <= 1'b0;
            exhausted_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            model_reg     <= model_next;
            started_reg   <= started_next;
            exhausted_reg <= exhausted_next;
        end
    end

    always_ff @(posedge clk) begin
        idx_reg  <= idx_next;
        val_reg  <= val_next;
        hold_reg <= hold_next;
        from_reg <= from_next;
    end

    assign pop_in_wide  = XW'(s_population);
    assign pop_out_wide = XW'(pool_rdata_reg);
    assign km1          = k_reg - SIZE_W'(1);
    assign k_try        = (from_reg < W6'(band.lo)) ? W6'(band.lo) : from_reg;
    assign in_band      = (k_reg != '0) && (k_reg >= band.lo) && (k_reg <= band.hi);
    // A position is finished once it reaches n - k + i.
    assign lim_lhs      = W6'(pos_rdata_reg) + W6'(k_reg);
    assign lim_rhs      = W6'(band.n) + W6'(idx_reg);
    assign at_limit     = (lim_lhs >= lim_rhs);
    assign idx_is_last  = (SIZE_W'(idx_reg) == km1);
    assign s_ready      = (state_reg == ST_IDLE);
    assign accept       = s_valid && s_ready;

    always_comb begin
        state_next     = state_reg;
        k_next         = k_reg;
        model_next     = model_reg;
        started_next   = started_reg;
        exhausted_next = exhausted_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        hold_next      = hold_reg;
        from_next      = from_reg;
        pos_we         = 1'b0;
        pos_waddr      = idx_reg;
        pos_wdata      = idx_reg;
        pos_re         = 1'b0;
        pos_raddr      = idx_reg;
        pool_we        = 1'b0;
        pool_waddr     = s_slot[IDX_W-1:0];
        pool_wdata     = pop_in_wide[POP_WIDTH-1:0];
        pool_re        = 1'b0;
        pool_raddr     = pos_rdata_reg;
        res_load       = 1'b0;
        res            = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_op)
                        OP_LOAD: begin
                            pool_we = ({1'b0, s_slot} < SIZE_W'(POOL_MAX));
                        end
                        OP_NEXT: begin
                            if (exhausted_reg) begin
                                state_next = ST_DONE;
                            end else if (!started_reg) begin
                                started_next = 1'b1;
                                from_next    = W6'(1);
                                state_next   = ST_BEGIN;
                            end else begin
                                state_next = ST_ADV;
                            end
                        end
                        OP_RESTART: begin
                            started_next   = 1'b0;
                            exhausted_next = 1'b0;
                            k_next         = '0;
                            model_next     = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_BEGIN: begin
                if (k_try > W6'(band.hi)) begin
                    state_next = ST_DONE;
                end else begin
                    k_next     = k_try[SIZE_W-1:0];
                    idx_next   = '0;
                    state_next = ST_INIT;
                end
            end
            ST_INIT: begin
                pos_we = 1'b1;
                if (idx_is_last) begin
                    idx_next   = '0;
                    state_next = ST_EMIT_RD;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_ADV: begin
                if (in_band) begin
                    pos_re     = 1'b1;
                    pos_raddr  = km1[IDX_W-1:0];
                    idx_next   = km1[IDX_W-1:0];
                    state_next = ST_SCAN;
                end else begin
                    from_next  = W6'(k_reg) + W6'(1);
                    state_next = ST_BEGIN;
                end
            end
            ST_SCAN: begin
                if (!at_limit) begin
                    pos_we    = 1'b1;
                    pos_wdata = pos_rdata_reg + IDX_W'(1);
                    val_next  = pos_rdata_reg + IDX_W'(2);
                    if (idx_is_last) begin
                        idx_next   = '0;
                        state_next = ST_EMIT_RD;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_FILL;
                    end
                end else if (idx_reg == '0) begin
                    from_next  = W6'(k_reg) + W6'(1);
                    state_next = ST_BEGIN;
                end else begin
                    pos_re    = 1'b1;
                    pos_raddr = idx_reg - IDX_W'(1);
                    idx_next  = idx_reg - IDX_W'(1);
                end
            end
            ST_FILL: begin
                pos_we    = 1'b1;
                pos_wdata = val_reg;
                val_next  = val_reg + IDX_W'(1);
                if (idx_is_last) begin
                    idx_next   = '0;
                    state_next = ST_EMIT_RD;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_EMIT_RD: begin
                pos_re     = 1'b1;
                state_next = ST_EMIT_PR;
            end
            ST_EMIT_PR: begin
                pool_re    = 1'b1;
                hold_next  = pos_rdata_reg;
                state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR: begin
                res.member_position   = POS_W'(hold_reg);
                res.member_population = pop_out_wide[PORT_POP_W-1:0];
                res.subset_size       = k_reg;
                res.model_number      = model_reg;
                res.last_member       = idx_is_last;
                if (out_free) begin
                    res_load = 1'b1;
                    if (idx_is_last) begin
                        model_next = model_reg + MODEL_W'(1);
                        state_next = ST_IDLE;
                    end else begin
                        pos_re     = 1'b1;
                        pos_raddr  = idx_reg + IDX_W'(1);
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_EMIT_PR;
                    end
                end
            end
            ST_DONE: begin
                res.done_res = 1'b1;
                if (out_free) begin
                    res_load       = 1'b1;
                    exhausted_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `SE_ASSERT_IMP(a_load_when_free, clk, rst_n, res_load, out_free)
    `SE_ASSERT_IMP(a_load_states, clk, rst_n, res_load,
                   (state_reg == ST_EMIT_WR) || (state_reg == ST_DONE))
    `SE_ASSERT_NXT(a_last_ends_item, clk, rst_n, res_load && res.last_member,
                   state_reg == ST_IDLE)
    `SE_ASSERT_IMP(a_no_pos_write_emit, clk, rst_n, pos_we,
                   (state_reg == ST_INIT) || (state_reg == ST_SCAN) || (state_reg == ST_FILL))
    `SE_ASSERT_IMP(a_pool_write_idle, clk, rst_n, pool_we, state_reg == ST_IDLE)
    `SE_ASSERT_IMP(a_exhausted_started, clk, rst_n, exhausted_reg, started_reg)

endmodule

// File: rtl/subset_enumerator.sv
// Subset enumerator: walks every subset of the first n pool slots whose size lies in
// the configured band, smallest size first and in lexicographic order within a size.
// Input channel (s_*): op 0 loads s_population into pool slot s_slot, op 1 asks for
// the next subset, op 2 restarts the walk; op 3 is ignored. Loads, restarts and
// op 3 stay idle. An op 1 transaction emits one result transaction on the m_*
// channel per subset member, the last one flagged, or a single done transaction
// once nothing is left. Configuration (cfg_*) is accepted every cycle and should
// only be written while the block is idle.
// An op 1 within one size scans positions back from the end, refills the ones after
// the advanced position and then emits the members; the first op 1 after a restart,
// or a move to a new size mid-walk, first writes all k positions anew, and a done
// result once the walk is over needs no scan. The time taken is set by the position
// memory, read once per member with the pool memory read chained behind it, and by
// the one-entry-per-cycle scan and refill.
// The block takes one op 1 at a time; s_ready is high whenever it is idle.
// A stalled receiver holds the output register and the walk waits in place.
// Reset (aresetn, synchronous) restores the register defaults and the walk state;
// the pool contents are not cleared and no clearing pass runs after reset.
module subset_enumerator #(
    parameter int POOL_MAX  = subenum_pkg::POOL_MAX_DEF,
    parameter int POP_WIDTH = subenum_pkg::POP_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [subenum_pkg::OP_W-1:0]       s_op,
    input  logic [subenum_pkg::SLOT_W-1:0]     s_slot,
    input  logic [subenum_pkg::PORT_POP_W-1:0] s_population,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [subenum_pkg::POS_W-1:0]      m_member_position,
    output logic [subenum_pkg::PORT_POP_W-1:0] m_member_population,
    output logic [subenum_pkg::SIZE_W-1:0]     m_subset_size,
    output logic [subenum_pkg::MODEL_W-1:0]    m_model_number,
    output logic                              m_last_member,
    output logic                              m_done_res,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [subenum_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [subenum_pkg::SIZE_W-1:0]     cfg_data
);
    import subenum_pkg::*;

    logic [SIZE_W-1:0] pool_size_reg, pool_size_next;
    logic [SIZE_W-1:0] min_size_reg, min_size_next;
    logic [SIZE_W-1:0] max_size_reg, max_size_next;
    band_t             band;
    result_t           res;
    result_t           res_reg, res_next;
    logic              res_load;
    logic              m_valid_reg, m_valid_next;
    logic              out_free;

    // The configuration port never stalls.
    assign cfg_ready = 1'b1;

    always_comb begin
        pool_size_next = pool_size_reg;
        min_size_next  = min_size_reg;
        max_size_next  = max_size_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_POOL_SIZE: pool_size_next = cfg_data;
                CFG_MIN_SIZE:  min_size_next  = cfg_data;
                CFG_MAX_SIZE:  max_size_next  = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_size_reg <= POOL_SIZE_RST;
            min_size_reg  <= MIN_SIZE_RST;
            max_size_reg  <= MAX_SIZE_RST;
        end else begin
            pool_size_reg <= pool_size_next;
            min_size_reg  <= min_size_next;
            max_size_reg  <= max_size_next;
        end
    end

    // The band: n is the pool size capped at the pool depth, a minimum of zero
    // acts as one, and the maximum is capped at n.
    always_comb begin
        band.n  = (pool_size_reg > SIZE_W'(POOL_MAX)) ? SIZE_W'(POOL_MAX) : pool_size_reg;
        band.lo = (min_size_reg == '0) ? SIZE_W'(1) : min_size_reg;
        band.hi = (max_size_reg > band.n) ? band.n : max_size_reg;
    end

    subenum_core #(
        .POOL_MAX  (POOL_MAX),
        .POP_WIDTH (POP_WIDTH)
    ) u_core (
        .clk          (aclk),
        .rst_n        (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_slot       (s_slot),
        .s_population (s_population),
        .band         (band),
        .out_free     (out_free),
        .res          (res),
        .res_load     (res_load)
    );

    // Output register: a new result may enter when the register is empty or
    // its current transaction completes in this cycle.
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        if (res_load) begin
            res_next     = res;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_member_position   = res_reg.member_position;
    assign m_member_population = res_reg.member_population;
    assign m_subset_size       = res_reg.subset_size;
    assign m_model_number      = res_reg.model_number;
    assign m_last_member       = res_reg.last_member;
    assign m_done_res          = res_reg.done_res;

endmodule

// File: verif/tb_subset_enumerator.sv
module tb_subset_enumerator;
    timeunit 1ns;
    timeprecision 1ps;

    import subenum_pkg::*;

    // Op code 3 is left undefined by the block and must be ignored by it.
    localparam logic [OP_W-1:0] OP_NOP = 2'd3;

    // The quiet time we allow before a register write and at the end of the run.
    localparam int unsigned SETTLE_CYCLES = 64;

    // Worst case is far below this: about 200 transactions, each with at most
    // sixteen results behind receiver stalls.
    localparam int unsigned LIMIT_CYCLES = 600000;

    localparam int unsigned RANDOM_ITEMS  = 160;
    localparam int unsigned RANDOM_PHASES = 10;
    localparam int unsigned REPORT_CAP    = 200;

    // This scoreboard keeps its own copy of the pool, the walk state and the
    // three band registers. Every accepted op 1 transaction is expanded into the
    // member or done results it should produce, and every result transaction that the
    // block emits is checked against the oldest of those.
    class subset_walk_board;
        logic [PORT_POP_W-1:0] pool_vals [POOL_MAX_DEF];
        int                    walk_pos [POOL_MAX_DEF];
        int                    cur_size;
        logic [MODEL_W-1:0]    model_cnt;
        bit                    walk_started;
        bit                    walk_over;
        logic [SIZE_W-1:0]     reg_pool;
        logic [SIZE_W-1:0]     reg_min;
        logic [SIZE_W-1:0]     reg_max;
        result_t               expected_members [$];
        int unsigned           mismatch_count;
        int unsigned           next_count;
        int unsigned           member_count;
        int unsigned           done_count;

        function new();
            clear_walk();
            reg_pool = POOL_SIZE_RST;
            reg_min  = MIN_SIZE_RST;
            reg_max  = MAX_SIZE_RST;
            mismatch_count = 0;
            next_count     = 0;
            member_count   = 0;
            done_count     = 0;
        endfunction

        function void clear_walk();
            foreach (walk_pos[i]) walk_pos[i] = 0;
            cur_size     = 0;
            model_cnt    = '0;
            walk_started = 1'b0;
            walk_over    = 1'b0;
        endfunction

        function void write_register(cfg_idx_t idx, logic [SIZE_W-1:0] val);
            case (idx)
                CFG_POOL_SIZE: reg_pool = val;
                CFG_MIN_SIZE:  reg_min  = val;
                CFG_MAX_SIZE:  reg_max  = val;
                default: ;
            endcase
        endfunction

        function int eff_n();
            return (reg_pool > POOL_MAX_DEF) ? POOL_MAX_DEF : int'(reg_pool);
        endfunction

        function int eff_lo();
            return (reg_min < 1) ? 1 : int'(reg_min);
        endfunction

        function int eff_hi();
            return (int'(reg_max) > eff_n()) ? eff_n() : int'(reg_max);
        endfunction

        // Start the smallest size at or above 'from' that lies in the band.
        function bit open_size(int from);
            int k;
            k = (from < eff_lo()) ? eff_lo() : from;
            if (k > eff_hi() || k < 1) return 1'b0;
            cur_size = k;
            foreach (walk_pos[i]) walk_pos[i] = (i < k) ? i : 0;
            return 1'b1;
        endfunction

        // Lexicographic successor within the current size, or the next size.
        // A size that fell outside the band after a register write ends at once.
        function bit step_walk();
            int n;
            int k;
            int i;
            n = eff_n();
            k = cur_size;
            if (k >= 1 && k <= POOL_MAX_DEF && k >= eff_lo() && k <= eff_hi()) begin
                i = k - 1;
                while (i >= 0 && walk_pos[i] >= n - k + i) i--;
                if (i >= 0) begin
                    walk_pos[i]++;
                    for (int j = i + 1; j < k; j++) walk_pos[j] = walk_pos[j - 1] + 1;
                    return 1'b1;
                end
            end
            return open_size(k + 1);
        endfunction

        // Appends one expected result behind those already waiting.
        function void queue_result(result_t r);
            expected_members.insert(expected_members.size(), r);
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                   logic [PORT_POP_W-1:0] pop);
            result_t r;
            bit      have;
            case (op)
                OP_LOAD:    pool_vals[slot] = pop;
                OP_RESTART: clear_walk();
                OP_NEXT: begin
                    next_count++;
                    if (walk_over) begin
                        have = 1'b0;
                    end else if (!walk_started) begin
                        walk_started = 1'b1;
                        have = open_size(1);
                    end else begin
                        have = step_walk();
                    end
                    if (!have) begin
                        walk_over  = 1'b1;
                        r          = '0;
                        r.done_res = 1'b1;
                        queue_result(r);
                    end else begin
                        for (int m = 0; m < cur_size; m++) begin
                            r.member_position   = walk_pos[m][POS_W-1:0];
                            r.member_population = pool_vals[walk_pos[m][POS_W-1:0]];
                            r.subset_size       = cur_size[SIZE_W-1:0];
                            r.model_number      = model_cnt;
                            r.last_member       = (m == cur_size - 1);
                            r.done_res          = 1'b0;
                            queue_result(r);
                        end
                        model_cnt++;
                    end
                end
                default: ;
            endcase
        endfunction

        function void report_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_CAP)
                    $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                             $time, name, want, got);
            end
        endfunction

        function void check_member(result_t got);
            result_t want;
            if (expected_members.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_CAP)
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, got);
                return;
            end
            want = expected_members.pop_front();
            if (want.done_res) done_count++;
            else member_count++;
            report_field("member_position", 16'(want.member_position),
                         16'(got.member_position));
            report_field("member_population", want.member_population,
                         got.member_population);
            report_field("subset_size", 16'(want.subset_size), 16'(got.subset_size));
            report_field("model_number", want.model_number, got.model_number);
            report_field("last_member", 16'(want.last_member), 16'(got.last_member));
            report_field("done_res", 16'(want.done_res), 16'(got.done_res));
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic                   aclk;
    logic                   aresetn      = 1'b0;
    logic                   s_valid      = 1'b0;
    logic                   s_ready;
    logic [OP_W-1:0]        s_op         = '0;
    logic [SLOT_W-1:0]      s_slot       = '0;
    logic [PORT_POP_W-1:0]  s_population = '0;
    logic                   m_valid;
    logic                   m_ready      = 1'b0;
    logic [POS_W-1:0]       m_member_position;
    logic [PORT_POP_W-1:0]  m_member_population;
    logic [SIZE_W-1:0]      m_subset_size;
    logic [MODEL_W-1:0]     m_model_number;
    logic                   m_last_member;
    logic                   m_done_res;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index    = '0;
    logic [SIZE_W-1:0]      cfg_data     = '0;

    subset_walk_board walk_board = new();

    int unsigned cycle_count = 0;
    int unsigned burst_left  = 0;
    int unsigned band_writes = 0;

    subset_enumerator u_top (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_op                (s_op),
        .s_slot              (s_slot),
        .s_population        (s_population),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_member_position   (m_member_position),
        .m_member_population (m_member_population),
        .m_subset_size       (m_subset_size),
        .m_model_number      (m_model_number),
        .m_last_member       (m_last_member),
        .m_done_res          (m_done_res),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // The monitor samples at the rising edge, before the block's registers
    // update, so it sees exactly what the handshake saw. A result is checked
    // before an input of the same edge is noted; the two cannot be related.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                walk_board.check_member(result_t'({m_member_position, m_member_population,
                                                   m_subset_size, m_model_number,
                                                   m_last_member, m_done_res}));
            if (cfg_valid && cfg_ready)
                walk_board.write_register(cfg_idx_t'(cfg_index), cfg_data);
            if (s_valid && s_ready)
                walk_board.note_request(s_op, s_slot, s_population);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, walk_board.expected_members.size());
            $display("** subset_enumerator: FAILED **");
            $finish;
        end
    end

    // The receiver switches between a few stall patterns: always ready, a coin
    // flip per cycle, a fixed duty cycle, and long stretches of stall and flow.
    int unsigned stall_mode = 0;
    int unsigned mode_left  = 0;
    int unsigned hold_left  = 0;
    always @(negedge aclk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(50, 300);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= (mode_left % 4) != 0;
            default: begin
                if (hold_left == 0) begin
                    m_ready  <= ~m_ready;
                    hold_left = $urandom_range(1, 16);
                end else begin
                    hold_left--;
                end
            end
        endcase
    end

    // The sender works in bursts. At the start of each burst it drops valid for
    // a random gap; some bursts are long, which gives stretches without idling.
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        burst_left--;
    endtask

    // Called at a falling edge; returns at the falling edge after the
    // transaction was taken, with valid still high for a following one.
    task automatic send_op(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                           logic [PORT_POP_W-1:0] pop);
        pace_sender();
        s_valid      <= 1'b1;
        s_op         <= op;
        s_slot       <= slot;
        s_population <= pop;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_random(logic [OP_W-1:0] op);
        send_op(op, SLOT_W'($urandom), PORT_POP_W'($urandom));
    endtask

    // Holds the sender off until every expected result has arrived, then
    // waits a further settle time. At least one falling edge always passes.
    task automatic drain_results(int unsigned settle);
        s_valid <= 1'b0;
        @(negedge aclk);
        while (walk_board.expected_members.size() != 0) @(negedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [SIZE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Register writes only happen with the block idle. The walk itself is not
    // restarted here, so a new band can take effect partway through a walk.
    task automatic program_band(logic [SIZE_W-1:0] pool, logic [SIZE_W-1:0] lo,
                                logic [SIZE_W-1:0] hi);
        drain_results(SETTLE_CYCLES);
        write_reg(CFG_POOL_SIZE, pool);
        write_reg(CFG_MIN_SIZE, lo);
        write_reg(CFG_MAX_SIZE, hi);
        cfg_valid <= 1'b0;
        band_writes++;
    endtask

    task automatic run_phase(int unsigned count);
        int unsigned sent;
        int unsigned roll;
        sent = 0;
        while (sent < count) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                // Let the block run dry before going on.
                drain_results(0);
            end else if (roll < 68) begin
                send_random(OP_NEXT);
                sent++;
            end else if (roll < 84) begin
                send_random(OP_LOAD);
                sent++;
            end else if (roll < 93) begin
                send_random(OP_RESTART);
                sent++;
            end else begin
                send_random(OP_NOP);
            end
        end
    endtask

    initial begin
        logic [SIZE_W-1:0] pool;
        logic [SIZE_W-1:0] lo;
        logic [SIZE_W-1:0] hi;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset band is a one-slot pool with sizes one and up. Slot 0 is loaded
        // first so that no member ever reads a slot that was never written.
        send_op(OP_LOAD, 4'd0, 16'hFFFF);
        send_random(OP_NEXT);
        // The walk is over: done comes back, and keeps coming until a restart.
        send_random(OP_NEXT);
        send_random(OP_NEXT);
        send_random(OP_NOP);
        send_random(OP_RESTART);
        send_random(OP_NEXT);

        // Fill the rest of the pool with extreme and random values.
        for (int s = 1; s < POOL_MAX_DEF; s++) begin
            case (s)
                1:       send_op(OP_LOAD, SLOT_W'(s), 16'h0000);
                2:       send_op(OP_LOAD, SLOT_W'(s), 16'hAAAA);
                3:       send_op(OP_LOAD, SLOT_W'(s), 16'h5555);
                default: send_op(OP_LOAD, SLOT_W'(s), PORT_POP_W'($urandom));
            endcase
        end

        // A single subset of all sixteen slots, reached mid-walk from size one,
        // then done, then the same subset again after a restart.
        program_band(5'd16, 5'd16, 5'd16);
        send_random(OP_NEXT);
        send_random(OP_NEXT);
        send_random(OP_RESTART);
        send_random(OP_NEXT);

        // Random phases. The first few pin the register extremes: a pool size
        // beyond the pool, zero pool, min above the pool, max of zero and a
        // band that is empty because min is above max.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin pool = 5'd31; lo = 5'd0;  hi = 5'd31; end
                1: begin pool = 5'd0;  lo = 5'd1;  hi = 5'd16; end
                2: begin pool = 5'd5;  lo = 5'd31; hi = 5'd2;  end
                3: begin pool = 5'd4;  lo = 5'd2;  hi = 5'd3;  end
                4: begin pool = 5'd3;  lo = 5'd0;  hi = 5'd0;  end
                5: begin pool = 5'd6;  lo = 5'd4;  hi = 5'd2;  end
                default: begin
                    // Mostly small pools, so walks run out and restarts matter.
                    pool = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom_range(0, 31))
                                                       : SIZE_W'($urandom_range(2, 6));
                    lo   = SIZE_W'($urandom_range(0, 4));
                    hi   = ($urandom_range(0, 3) == 0) ? 5'd31
                                                       : SIZE_W'($urandom_range(0, 6));
                end
            endcase
            program_band(pool, lo, hi);
            if ($urandom_range(0, 1) == 1) send_random(OP_RESTART);
            run_phase(RANDOM_ITEMS / RANDOM_PHASES);
        end

        drain_results(SETTLE_CYCLES);

        $display("Covered %0d next requests over %0d band settings: %0d members and %0d",
                 walk_board.next_count, band_writes, walk_board.member_count,
                 walk_board.done_count);
        $display("done results checked, %0d mismatches.", walk_board.mismatch_count);
        if (walk_board.mismatch_count == 0 && walk_board.expected_members.size() == 0) begin
            $display("** subset_enumerator: PASSED **");
        end else begin
            $display("** subset_enumerator: FAILED **");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/subenum_pkg.sv
rtl/subenum_core.sv
rtl/subset_enumerator.sv
verif/tb_subset_enumerator.sv
